// ===== hdl/wsfu_pkg.sv =====
// Package for the WebSocket frame unmasker.
// Holds the request and result structs, result kind codes and header constants.
// No dependencies.
package wsfu_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // Lengths from this value upward announce an extended length field.
  localparam logic [6:0] LEN_EXTENDED = 7'd126;
  localparam int         KEY_BYTES    = 4;
  localparam logic [1:0] KEY_LAST_IDX = 2'(KEY_BYTES - 1);

  typedef struct packed {
    logic       frame_start;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic       fin;
    logic [3:0] opcode;
    logic       masked;
    logic [6:0] payload_length;
    logic [7:0] data_out;
    logic       last;
  } out_item_t;

endpackage

// ===== hdl/websocket_frame_unmasker.sv =====
// WebSocket frame deframer and unmasker, top level.
// Parses the base header, collects the masking key, emits header, payload and error results.
// Depends on wsfu_pkg.

// One received byte per clock is taken, back to back, and the result of each
// request is registered in the output register. A byte flagged frame_start
// begins a frame (FIN and opcode); the next byte gives MASK and the 7-bit
// length and yields a header result; four key bytes follow when MASK is set
// and yield nothing; each payload byte yields one unmasked result, the final
// one marked last. Lengths 126 and 127 yield one error result, after which
// bytes are dropped until the next frame_start. Input is accepted whenever the
// output register is empty or being emptied in the same cycle, so a stalled
// result holds the input side only for as long as it stays untaken.
module websocket_frame_unmasker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wsfu_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output wsfu_pkg::out_item_t out_item
);
  import wsfu_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_KEY,
    PH_DATA,
    PH_DROP
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [4:0] fin_op_r, fin_op_nxt;
  logic       mask_r, mask_nxt;
  logic [1:0] key_cnt_r, key_cnt_nxt;
  logic [6:0] len_r, len_nxt;
  logic [6:0] idx_r, idx_nxt;
  logic [7:0] key_r [KEY_BYTES];
  logic       key_we;

  logic       out_valid_r;
  out_item_t  out_item_r;

  logic       take;
  logic       res_valid;
  out_item_t  res;
  logic [7:0] key_byte;
  logic [6:0] idx_inc;

  assign in_ready  = ~out_valid_r | out_ready;
  assign take      = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign idx_inc  = idx_r + 7'd1;
  assign key_byte = mask_r ? key_r[idx_r[1:0]] : 8'h00;

  always_comb begin
    phase_nxt   = phase_r;
    fin_op_nxt  = fin_op_r;
    mask_nxt    = mask_r;
    key_cnt_nxt = key_cnt_r;
    len_nxt     = len_r;
    idx_nxt     = idx_r;
    key_we      = 1'b0;
    res_valid   = 1'b0;
    res         = '{kind: KIND_HEADER, fin: fin_op_r[4], opcode: fin_op_r[3:0],
                    masked: mask_r, payload_length: len_r, data_out: 8'h00,
                    last: 1'b0};
    if (take) begin
      if (in_item.frame_start) begin
        // restart: abandon any unfinished frame
        fin_op_nxt  = {in_item.data_byte[7], in_item.data_byte[3:0]};
        mask_nxt    = 1'b0;
        key_cnt_nxt = '0;
        len_nxt     = '0;
        idx_nxt     = '0;
        phase_nxt   = PH_LEN;
      end else begin
        unique case (phase_r)
          PH_LEN: begin
            mask_nxt   = in_item.data_byte[7];
            res.masked = in_item.data_byte[7];
            res_valid  = 1'b1;
            if (in_item.data_byte[6:0] >= LEN_EXTENDED) begin
              res.kind           = KIND_ERROR;
              res.payload_length = '0;
              res.last           = 1'b1;
              phase_nxt          = PH_DROP;
            end else begin
              len_nxt            = in_item.data_byte[6:0];
              idx_nxt            = '0;
              key_cnt_nxt        = '0;
              res.payload_length = in_item.data_byte[6:0];
              res.last           = (in_item.data_byte[6:0] == 7'd0);
              if (in_item.data_byte[7]) begin
                phase_nxt = PH_KEY;
              end else if (in_item.data_byte[6:0] != 7'd0) begin
                phase_nxt = PH_DATA;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
          end
          PH_KEY: begin
            key_we      = 1'b1;
            key_cnt_nxt = key_cnt_r + 2'd1;
            if (key_cnt_r == KEY_LAST_IDX) begin
              phase_nxt = (len_r != 7'd0) ? PH_DATA : PH_IDLE;
            end
          end
          PH_DATA: begin
            res_valid    = 1'b1;
            res.kind     = KIND_PAYLOAD;
            res.data_out = in_item.data_byte ^ key_byte;
            res.last     = (idx_inc == len_r);
            idx_nxt      = idx_inc;
            if (idx_inc == len_r) begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_IDLE, PH_DROP: begin
            // drop bytes outside a frame
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      fin_op_r    <= '0;
      mask_r      <= 1'b0;
      key_cnt_r   <= '0;
      len_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      fin_op_r  <= fin_op_nxt;
      mask_r    <= mask_nxt;
      key_cnt_r <= key_cnt_nxt;
      len_r     <= len_nxt;
      idx_r     <= idx_nxt;
      if (in_ready) begin
        out_valid_r <= res_valid;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_r[key_cnt_r] <= in_item.data_byte;
    end
    if (in_ready && res_valid) begin
      out_item_r <= res;
    end
  end

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.kind == KIND_ERROR |->
      out_item_r.last && out_item_r.payload_length == 7'd0)
    else $error("error result not closing frame");

  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> len_r != 7'd0 && idx_r < len_r)
    else $error("payload index out of range");

  a_hdr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.kind != KIND_PAYLOAD |-> out_item_r.data_out == 8'h00)
    else $error("nonzero data on header or error result");

  a_key_done: assert property (@(posedge clk) disable iff (!rst_n)
    $past(phase_r) == PH_KEY && phase_r == PH_DATA |-> key_cnt_r == 2'd0)
    else $error("payload started before full key");

endmodule
